### sv/mrac_pkg.sv
// Package for the multi-resource admission counter: codes, types and default sizes.
`default_nettype none
package mrac_pkg;

  localparam int DEF_STORES     = 16;
  localparam int DEF_CLIENTS    = 64;
  localparam int DEF_JOB_DEFS   = 64;
  localparam int DEF_COUNT_BITS = 8;

  localparam int STORE_IDX_W  = 4;
  localparam int CLIENT_IDX_W = 6;
  localparam int JOB_IDX_W    = 6;
  localparam int LIMIT_W      = 8;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_WAIT_STORE  = 3'd1,
    ST_WAIT_CLIENT = 3'd2,
    ST_WAIT_JOB    = 3'd3,
    ST_CANCEL      = 3'd4
  } status_t;

endpackage
`default_nettype wire

### sv/multi_resource_admission_counter_core.sv
// Multi-resource admission counter: per-resource concurrency counters with grant and release.
// A request accepted at one clock edge is evaluated in the following cycle against the
// counters; its result is shown on the out_ ports in the next cycle, for exactly one cycle.
// A new request is taken every cycle, as each counter is a cell of its own that updates
// in the same cycle. busy stays low.
// Synchronous active-low reset clears every counter and the request and result strobes.
`default_nettype none
module multi_resource_admission_counter_core
  import mrac_pkg::*;
#(
  parameter int STORES     = DEF_STORES,
  parameter int CLIENTS    = DEF_CLIENTS,
  parameter int JOB_DEFS   = DEF_JOB_DEFS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    in_op,
  input  wire logic                    in_read_store_valid,
  input  wire logic [STORE_IDX_W-1:0]  in_read_store,
  input  wire logic                    in_write_store_valid,
  input  wire logic [STORE_IDX_W-1:0]  in_write_store,
  input  wire logic [CLIENT_IDX_W-1:0] in_client_index,
  input  wire logic [JOB_IDX_W-1:0]    in_job_def_index,
  input  wire logic [LIMIT_W-1:0]      in_write_store_limit,
  input  wire logic [LIMIT_W-1:0]      in_client_limit,
  input  wire logic [LIMIT_W-1:0]      in_job_def_limit,
  output logic                         out_valid,
  output logic                         out_granted,
  output logic [2:0]                   out_status
);

  localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  // Request register
  logic                    req_vld_r;
  op_t                     op_r;
  logic                    rv_r;
  logic [STORE_IDX_W-1:0]  rs_r;
  logic                    wv_r;
  logic [STORE_IDX_W-1:0]  ws_r;
  logic [CLIENT_IDX_W-1:0] cl_r;
  logic [JOB_IDX_W-1:0]    jd_r;
  logic [LIMIT_W-1:0]      wlim_r;
  logic [LIMIT_W-1:0]      clim_r;
  logic [LIMIT_W-1:0]      jlim_r;

  // Result register
  logic    out_valid_r;
  logic    out_granted_r;
  status_t out_status_r;
  logic    out_granted_nxt;
  status_t out_status_nxt;

  // Counter cells
  logic [COUNT_BITS-1:0] store_cnt_r  [STORES];
  logic [COUNT_BITS-1:0] store_cnt_nxt[STORES];
  logic [COUNT_BITS-1:0] cl_cnt_r     [CLIENTS];
  logic [COUNT_BITS-1:0] cl_cnt_nxt   [CLIENTS];
  logic [COUNT_BITS-1:0] jd_cnt_r     [JOB_DEFS];
  logic [COUNT_BITS-1:0] jd_cnt_nxt   [JOB_DEFS];

  logic [STORES-1:0]   rs_busy_v;
  logic [STORES-1:0]   ws_room_v;
  logic [CLIENTS-1:0]  cl_room_v;
  logic [JOB_DEFS-1:0] jd_room_v;

  logic accept;
  logic rs_ok, ws_ok, cl_ok, jd_ok;
  logic fail_rd, cancel, fail_ws, fail_cl, fail_jd;
  logic acq_grant, do_release;

  function automatic logic has_room(input logic [COUNT_BITS-1:0] cnt,
                                    input logic [LIMIT_W-1:0] lim);
    return (CMP_W'(cnt) < CMP_W'(lim)) && (cnt != CNT_MAX);
  endfunction

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_op);
      rv_r   <= in_read_store_valid;
      rs_r   <= in_read_store;
      wv_r   <= in_write_store_valid;
      ws_r   <= in_write_store;
      cl_r   <= in_client_index;
      jd_r   <= in_job_def_index;
      wlim_r <= in_write_store_limit;
      clim_r <= in_client_limit;
      jlim_r <= in_job_def_limit;
    end
  end

  assign rs_ok = int'(rs_r) < STORES;
  assign ws_ok = int'(ws_r) < STORES;
  assign cl_ok = int'(cl_r) < CLIENTS;
  assign jd_ok = int'(jd_r) < JOB_DEFS;

  // Each cell reports on itself when addressed; the reports are OR-ed together.
  for (genvar i = 0; i < STORES; i++) begin : g_store_flag
    assign rs_busy_v[i] = (int'(rs_r) == i) && (store_cnt_r[i] != '0);
    assign ws_room_v[i] = (int'(ws_r) == i) && has_room(store_cnt_r[i], wlim_r);
  end
  for (genvar i = 0; i < CLIENTS; i++) begin : g_cl_flag
    assign cl_room_v[i] = (int'(cl_r) == i) && has_room(cl_cnt_r[i], clim_r);
  end
  for (genvar i = 0; i < JOB_DEFS; i++) begin : g_jd_flag
    assign jd_room_v[i] = (int'(jd_r) == i) && has_room(jd_cnt_r[i], jlim_r);
  end

  // Checks in the order of the acquire sequence. A failure at any step leaves the
  // counters as they were, so on an acquire only a full grant changes them.
  always_comb begin
    fail_rd = rv_r && (!rs_ok || (|rs_busy_v));
    cancel  = !fail_rd && rv_r && wv_r && (rs_r == ws_r);
    fail_ws = !fail_rd && !cancel && wv_r && (!ws_ok || !(|ws_room_v));
    fail_cl = !fail_rd && !cancel && !fail_ws && (!cl_ok || !(|cl_room_v));
    fail_jd = !fail_rd && !cancel && !fail_ws && !fail_cl && (!jd_ok || !(|jd_room_v));
  end

  assign acq_grant  = req_vld_r && (op_r == OP_ACQUIRE) && !fail_rd && !cancel &&
                      !fail_ws && !fail_cl && !fail_jd;
  assign do_release = req_vld_r && (op_r == OP_RELEASE);

  always_comb begin
    out_granted_nxt = 1'b0;
    out_status_nxt  = ST_OK;
    if (op_r == OP_RELEASE) begin
      out_granted_nxt = 1'b1;
    end else begin
      priority if (fail_rd) begin
        out_status_nxt = ST_WAIT_STORE;
      end else if (cancel) begin
        out_status_nxt = ST_CANCEL;
      end else if (fail_ws) begin
        out_status_nxt = ST_WAIT_STORE;
      end else if (fail_cl) begin
        out_status_nxt = ST_WAIT_CLIENT;
      end else if (fail_jd) begin
        out_status_nxt = ST_WAIT_JOB;
      end else begin
        out_granted_nxt = 1'b1;
      end
    end
  end

  // Storage cells: a release of the read storage clears the count, which also covers
  // a release naming the same device for reading and writing.
  for (genvar i = 0; i < STORES; i++) begin : g_store_cell
    logic rd_hit, wr_hit;
    assign rd_hit = rv_r && (int'(rs_r) == i);
    assign wr_hit = wv_r && (int'(ws_r) == i);
    always_comb begin
      store_cnt_nxt[i] = store_cnt_r[i];
      if (do_release) begin
        priority if (rd_hit) begin
          store_cnt_nxt[i] = '0;
        end else if (wr_hit && (store_cnt_r[i] != '0)) begin
          store_cnt_nxt[i] = store_cnt_r[i] - CNT_ONE;
        end else begin
          store_cnt_nxt[i] = store_cnt_r[i];
        end
      end else if (acq_grant) begin
        priority if (rd_hit) begin
          store_cnt_nxt[i] = CNT_ONE;
        end else if (wr_hit) begin
          store_cnt_nxt[i] = store_cnt_r[i] + CNT_ONE;
        end else begin
          store_cnt_nxt[i] = store_cnt_r[i];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        store_cnt_r[i] <= '0;
      end else begin
        store_cnt_r[i] <= store_cnt_nxt[i];
      end
    end
  end

  for (genvar i = 0; i < CLIENTS; i++) begin : g_cl_cell
    logic hit;
    assign hit = int'(cl_r) == i;
    always_comb begin
      cl_cnt_nxt[i] = cl_cnt_r[i];
      if (hit && do_release && (cl_cnt_r[i] != '0)) begin
        cl_cnt_nxt[i] = cl_cnt_r[i] - CNT_ONE;
      end else if (hit && acq_grant) begin
        cl_cnt_nxt[i] = cl_cnt_r[i] + CNT_ONE;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cl_cnt_r[i] <= '0;
      end else begin
        cl_cnt_r[i] <= cl_cnt_nxt[i];
      end
    end
  end

  for (genvar i = 0; i < JOB_DEFS; i++) begin : g_jd_cell
    logic hit;
    assign hit = int'(jd_r) == i;
    always_comb begin
      jd_cnt_nxt[i] = jd_cnt_r[i];
      if (hit && do_release && (jd_cnt_r[i] != '0)) begin
        jd_cnt_nxt[i] = jd_cnt_r[i] - CNT_ONE;
      end else if (hit && acq_grant) begin
        jd_cnt_nxt[i] = jd_cnt_r[i] + CNT_ONE;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        jd_cnt_r[i] <= '0;
      end else begin
        jd_cnt_r[i] <= jd_cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req_vld_r) begin
      out_granted_r <= out_granted_nxt;
      out_status_r  <= out_status_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_granted = out_granted_r;
  assign out_status  = out_status_r;

endmodule
`default_nettype wire
